/* rtl/brr_pkg.sv */
// Shared types and constants for the block ADPCM decoder.
package brr_pkg;

  // Stop after this many blocks from sound start.
  localparam logic [12:0] MAX_BLOCKS = 13'd4096;

  // Queue between front and back.
  localparam int JQ_DEPTH = 4;
  localparam int JQ_AW    = $clog2(JQ_DEPTH);

  // Result queue at the output.
  localparam int OQ_DEPTH = 4;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // One data byte with the block context it decodes under.
  typedef struct packed {
    logic [7:0]  nibbles;
    logic [3:0]  shift;
    logic [1:0]  filter;
    logic        clear_hist;
    logic        end_now;
    logic        loop_now;
    logic [11:0] idx;
  } job_t;

  // One result word.
  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               sound_end;
    logic               loop_flag;
    logic [11:0]        block_index;
  } res_t;

endpackage

/* rtl/brr_front.sv */
// Front end: parses headers, tracks block position and stop, issues data-byte jobs.
module brr_front (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic        new_sound,
  input  logic        push,
  output logic        full,
  output brr_pkg::job_t job,
  output logic        job_push,
  input  logic        job_full
);
  import brr_pkg::*;

  logic [3:0]  pos, pos_next;
  logic [3:0]  hdr_shift, hdr_shift_next;
  logic [1:0]  hdr_filter, hdr_filter_next;
  logic        hdr_end, hdr_end_next;
  logic        hdr_loop, hdr_loop_next;
  logic [12:0] count, count_next;
  logic        stopped, stopped_next;
  logic        pend_clear, pend_clear_next;

  logic        accept;
  logic [3:0]  pos_eff;
  logic [12:0] count_eff;
  logic [12:0] count_inc;
  logic        stopped_eff;
  logic        clear_eff;
  logic        last_byte;
  logic        end_now;

  assign full   = job_full;
  assign accept = push && !job_full;

  always_comb begin
    pos_eff     = new_sound ? 4'd0  : pos;
    count_eff   = new_sound ? 13'd0 : count;
    stopped_eff = new_sound ? 1'b0  : stopped;
    clear_eff   = new_sound || pend_clear;
    count_inc   = count_eff + 13'd1;
    last_byte   = (pos_eff >= 4'd8);
    end_now     = last_byte && (hdr_end || (count_inc >= MAX_BLOCKS));

    pos_next        = pos;
    count_next      = count;
    stopped_next    = stopped;
    pend_clear_next = pend_clear;
    hdr_shift_next  = hdr_shift;
    hdr_filter_next = hdr_filter;
    hdr_end_next    = hdr_end;
    hdr_loop_next   = hdr_loop;
    job_push        = 1'b0;

    job.nibbles    = data_byte;
    job.shift      = hdr_shift;
    job.filter     = hdr_filter;
    job.clear_hist = clear_eff;
    job.end_now    = end_now;
    job.loop_now   = end_now && hdr_end && hdr_loop;
    job.idx        = count_eff[11:0];

    if (accept) begin
      pos_next        = pos_eff;
      count_next      = count_eff;
      stopped_next    = stopped_eff;
      pend_clear_next = clear_eff;
      if (!stopped_eff) begin
        if (pos_eff == 4'd0) begin
          hdr_shift_next  = data_byte[7:4];
          hdr_filter_next = data_byte[3:2];
          hdr_loop_next   = data_byte[1];
          hdr_end_next    = data_byte[0];
          pos_next        = 4'd1;
        end else begin
          job_push        = 1'b1;
          pend_clear_next = 1'b0;
          if (last_byte) begin
            pos_next     = 4'd0;
            count_next   = count_inc;
            stopped_next = end_now;
          end else begin
            pos_next = pos_eff + 4'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      count      <= '0;
      stopped    <= 1'b0;
      pend_clear <= 1'b0;
      hdr_shift  <= '0;
      hdr_filter <= '0;
      hdr_end    <= 1'b0;
      hdr_loop   <= 1'b0;
    end else begin
      pos        <= pos_next;
      count      <= count_next;
      stopped    <= stopped_next;
      pend_clear <= pend_clear_next;
      hdr_shift  <= hdr_shift_next;
      hdr_filter <= hdr_filter_next;
      hdr_end    <= hdr_end_next;
      hdr_loop   <= hdr_loop_next;
    end
  end

endmodule

/* rtl/brr_job_queue.sv */
// Short job queue that decouples the front end from the sample datapath.
module brr_job_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  brr_pkg::job_t wr_job,
  output logic          q_full,
  input  logic          rd,
  output brr_pkg::job_t rd_job,
  output logic          q_valid
);
  import brr_pkg::*;

  job_t             mem [JQ_DEPTH];
  logic [JQ_AW-1:0] wr_ptr, rd_ptr;
  logic [JQ_AW:0]   cnt;
  logic             do_wr, do_rd;

  assign q_full  = (cnt == (JQ_AW+1)'(JQ_DEPTH));
  assign q_valid = (cnt != '0);
  assign rd_job  = mem[rd_ptr];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

/* rtl/brr_back.sv */
// Back end: history, result queue; one sample per cycle from jobs while not full.
module brr_back (
  input  logic               clk,
  input  logic               rst,
  input  brr_pkg::job_t      job,
  input  logic               job_valid,
  output logic               job_pop,
  output logic signed [15:0] sample,
  output logic               last,
  output logic               sound_end,
  output logic               loop_flag,
  output logic [11:0]        block_index,
  output logic               empty,
  input  logic               pop
);
  import brr_pkg::*;

  logic signed [15:0] prior, older;
  logic               phase;

  res_t               oq [OQ_DEPTH];
  logic [OQ_AW-1:0]   wr_ptr, rd_ptr;
  logic [OQ_AW:0]     cnt;
  logic               oq_full;
  logic               go;
  logic               do_rd;

  logic [3:0]         nib;
  logic signed [20:0] n_w, delta, p_w, q_w, pred, sum;
  logic signed [20:0] p3, p13, q3;
  logic signed [15:0] s;
  res_t               res;

  assign oq_full = (cnt == (OQ_AW+1)'(OQ_DEPTH));
  assign empty   = (cnt == '0);
  assign go      = job_valid && !oq_full;
  assign job_pop = go && phase;
  assign do_rd   = pop && !empty;

  always_comb begin
    nib = phase ? job.nibbles[3:0] : job.nibbles[7:4];
    n_w = {{17{nib[3]}}, nib};
    if (job.shift <= 4'd12) delta = (n_w <<< job.shift) >>> 1;
    else                    delta = nib[3] ? -21'sd2048 : 21'sd0;

    // history clears on the first sample after a new sound
    if (job.clear_hist && !phase) begin
      p_w = '0;
      q_w = '0;
    end else begin
      p_w = {{5{prior[15]}}, prior};
      q_w = {{5{older[15]}}, older};
    end
    p3  = (p_w <<< 1) + p_w;
    p13 = (p_w <<< 3) + (p_w <<< 2) + p_w;
    q3  = (q_w <<< 1) + q_w;

    case (job.filter)
      2'd1:    pred = p_w + ((-p_w) >>> 4);
      2'd2:    pred = (p_w <<< 1) + ((-p3) >>> 5) - q_w + (q_w >>> 4);
      2'd3:    pred = (p_w <<< 1) + ((-p13) >>> 6) - q_w + (q3 >>> 4);
      default: pred = '0;
    endcase

    sum = pred + delta;
    if (sum > 21'sd32767)       s = 16'sh7fff;
    else if (sum < -21'sd32768) s = -16'sh8000;
    else                        s = sum[15:0];

    res.sample      = s;
    res.last        = phase;
    res.sound_end   = phase && job.end_now;
    res.loop_flag   = phase && job.loop_now;
    res.block_index = job.idx;
  end

  always_ff @(posedge clk) begin
    if (go) oq[wr_ptr] <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older <= '0;
      prior <= '0;
    end else if (go) begin
      older <= p_w[15:0];
      prior <= s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (go) begin
        phase  <= !phase;
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({go, do_rd})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign sample      = oq[rd_ptr].sample;
  assign last        = oq[rd_ptr].last;
  assign sound_end   = oq[rd_ptr].sound_end;
  assign loop_flag   = oq[rd_ptr].loop_flag;
  assign block_index = oq[rd_ptr].block_index;

endmodule

/* rtl/brr_adpcm_decoder_unit.sv */
// Top level of the block ADPCM decoder: front end, job queue, sample back end.
// Flow: an accepted data byte goes into the job queue, and the back end writes
//   its two samples to the result queue in turn; header bytes produce no word.
// Throughput: one byte per cycle into the front while full is low; the back end
//   makes one sample per cycle unless stalled, and each data byte needs two.
// Reset: rst is synchronous, active high; clears position, history and queues.
module brr_adpcm_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         data_byte,
  input  logic               new_sound,
  input  logic               push,
  output logic               full,
  output logic signed [15:0] sample,
  output logic               last,
  output logic               sound_end,
  output logic               loop_flag,
  output logic [11:0]        block_index,
  output logic               empty,
  input  logic               pop
);
  import brr_pkg::*;

  // front -> queue
  job_t in_job;
  logic in_job_push;
  logic jq_full;

  // queue -> back
  job_t head_job;
  logic head_valid;
  logic head_pop;

  // Front: header parse, block position, block cap and stop handling.
  // Stopped bytes are swallowed here and never reach the queue.
  brr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .data_byte (data_byte),
    .new_sound (new_sound),
    .push      (push),
    .full      (full),
    .job       (in_job),
    .job_push  (in_job_push),
    .job_full  (jq_full)
  );

  // Decoupling queue; full back-pressures the input side.
  brr_job_queue u_jq (
    .clk     (clk),
    .rst     (rst),
    .wr      (in_job_push),
    .wr_job  (in_job),
    .q_full  (jq_full),
    .rd      (head_pop),
    .rd_job  (head_job),
    .q_valid (head_valid)
  );

  // Back: two serial samples per job, history kept here, result queue at the port.
  brr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (head_job),
    .job_valid   (head_valid),
    .job_pop     (head_pop),
    .sample      (sample),
    .last        (last),
    .sound_end   (sound_end),
    .loop_flag   (loop_flag),
    .block_index (block_index),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

/* rtl/brr_chk.sv */
// Port-level checks for the decoder top level, with bind.
module brr_chk (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic        last,
  input logic        sound_end,
  input logic        loop_flag,
  input logic [15:0] sample
);

  // result queue comes up empty
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  // second sample of a pair is always right behind the first
  a_pair: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !last) |=> !empty)
    else $error("low-nibble sample missing after high-nibble sample");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && sound_end) |-> last)
    else $error("sound_end on a high-nibble sample");

  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && loop_flag) |-> sound_end)
    else $error("loop_flag without sound_end");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(sample)))
    else $error("waiting word changed");

endmodule

bind brr_adpcm_decoder_unit brr_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .empty     (empty),
  .pop       (pop),
  .last      (last),
  .sound_end (sound_end),
  .loop_flag (loop_flag),
  .sample    (sample)
);

/* tb/brr_adpcm_decoder_unit_tb.sv */
// Self-checking testbench for the block ADPCM decoder: scoreboard class plus driver tasks.
module brr_adpcm_decoder_unit_tb;
  import brr_pkg::*;

  // Scoreboard: keeps its own copy of the decoder state, works out the words that
  // each accepted byte should give and checks the words that come out.
  class adpcm_scoreboard;
    res_t               expected_q[$];
    int unsigned        errors;
    int unsigned        words_checked;
    int unsigned        sounds_closed;
    int unsigned        cap_stops;
    int unsigned        bytes_dropped;

    logic [3:0]         pos;
    logic [3:0]         shift;
    logic [1:0]         filter;
    logic               hdr_end;
    logic               hdr_loop;
    logic signed [15:0] prior;
    logic signed [15:0] older;
    logic [12:0]        blocks;
    logic               halted;

    function new();
      pos      = '0;
      shift    = '0;
      filter   = '0;
      hdr_end  = 1'b0;
      hdr_loop = 1'b0;
      prior    = '0;
      older    = '0;
      blocks   = '0;
      halted   = 1'b0;
    endfunction

    function logic signed [15:0] decode_nibble(logic [3:0] nib);
      int n;
      int p;
      int q;
      int delta;
      int guess;
      int s;
      n = int'($signed(nib));
      p = int'(prior);
      q = int'(older);
      if (shift <= 4'd12) begin
        delta = (n * (1 << shift)) >>> 1;
      end else begin
        delta = (n < 0) ? -2048 : 0;
      end
      case (filter)
        2'd1: guess = p + ((-p) >>> 4);
        2'd2: guess = 2 * p + ((-3 * p) >>> 5) - q + (q >>> 4);
        2'd3: guess = 2 * p + ((-13 * p) >>> 6) - q + ((3 * q) >>> 4);
        default: guess = 0;
      endcase
      s = guess + delta;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      older = prior;
      prior = s[15:0];
      return s[15:0];
    endfunction

    // Returns 1 when the byte is taken by the decoder, 0 when it is dropped.
    function bit note_byte(logic [7:0] b, logic ns);
      res_t       w0;
      res_t       w1;
      logic [11:0] idx;
      logic       end_now;
      logic       loop_now;
      if (ns) begin
        prior  = '0;
        older  = '0;
        pos    = '0;
        blocks = '0;
        halted = 1'b0;
      end
      if (halted) begin
        bytes_dropped++;
        return 1'b0;
      end
      if (pos == 4'd0) begin
        shift    = b[7:4];
        filter   = b[3:2];
        hdr_loop = b[1];
        hdr_end  = b[0];
        pos      = 4'd1;
        return 1'b1;
      end
      idx = blocks[11:0];
      w0.sample = decode_nibble(b[7:4]);
      w1.sample = decode_nibble(b[3:0]);
      end_now  = 1'b0;
      loop_now = 1'b0;
      if (pos >= 4'd8) begin
        pos    = 4'd0;
        blocks = blocks + 13'd1;
        if (hdr_end) begin
          end_now  = 1'b1;
          loop_now = hdr_loop;
        end else if (blocks >= MAX_BLOCKS) begin
          end_now = 1'b1;
          cap_stops++;
        end
        if (end_now) begin
          halted = 1'b1;
          sounds_closed++;
        end
      end else begin
        pos = pos + 4'd1;
      end
      w0.last        = 1'b0;
      w0.sound_end   = 1'b0;
      w0.loop_flag   = 1'b0;
      w0.block_index = idx;
      w1.last        = 1'b1;
      w1.sound_end   = end_now;
      w1.loop_flag   = loop_now;
      w1.block_index = idx;
      expected_q.insert(expected_q.size(), w0);
      expected_q.insert(expected_q.size(), w1);
      return 1'b1;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH (word %0d): %s", words_checked, msg);
    endtask

    task check_word(logic signed [15:0] s, logic l, logic se, logic lf, logic [11:0] bi);
      res_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("word with nothing expected, sample=%0d", s));
        return;
      end
      want = expected_q.pop_front();
      if (s !== want.sample)
        report($sformatf("sample got %0d want %0d", s, want.sample));
      if (l !== want.last)
        report($sformatf("last got %b want %b", l, want.last));
      if (se !== want.sound_end)
        report($sformatf("sound_end got %b want %b", se, want.sound_end));
      if (lf !== want.loop_flag)
        report($sformatf("loop_flag got %b want %b", lf, want.loop_flag));
      if (bi !== want.block_index)
        report($sformatf("block_index got %0d want %0d", bi, want.block_index));
      words_checked++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [7:0]         data_byte = '0;
  logic               new_sound = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic signed [15:0] sample;
  logic               last;
  logic               sound_end;
  logic               loop_flag;
  logic [11:0]        block_index;
  logic               empty;
  logic               pop = 1'b0;

  adpcm_scoreboard sb = new();

  // Run control shared between the sender (main process) and the receiver.
  bit          tx_calm = 1'b0;   // no gaps between bytes
  bit          rx_calm = 1'b0;   // no pop stalls
  bit          hold_go = 1'b0;   // ask the receiver for one long hold-off
  int unsigned live_items;       // bytes taken by the decoder (not dropped)
  int unsigned random_start;
  logic [8:0]  opening [0:25];   // {new_sound, data_byte}

  brr_adpcm_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (data_byte),
    .new_sound   (new_sound),
    .push        (push),
    .full        (full),
    .sample      (sample),
    .last        (last),
    .sound_end   (sound_end),
    .loop_flag   (loop_flag),
    .block_index (block_index),
    .empty       (empty),
    .pop         (pop)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offer one byte and wait until it is taken. Inputs change only right after
  // a rising edge, and full is read in the same step, so it still shows the
  // value the DUT saw at that edge. push stays high when the next byte follows
  // straight away; an idle burst lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic ns);
    data_byte <= b;
    new_sound <= ns;
    push      <= 1'b1;
    do @(posedge clk); while (full);
    if (sb.note_byte(b, ns)) live_items++;
    if (!tx_calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every expected word. Waiting for an edge after
  // lowering push keeps a following raise out of the same time step.
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // One well-formed sound: nblk blocks of random content, opened by new_sound.
  // The end flag is set on the final header only when with_end is set; tail
  // adds a few bytes after the sound, which are dropped if it has stopped.
  task automatic play_sound(input int nblk, input bit with_end, input bit tail);
    logic [7:0] hdr;
    int         k;
    int         j;
    for (k = 0; k < nblk; k++) begin
      hdr    = 8'($urandom);
      hdr[0] = with_end && (k == nblk - 1);
      send_byte(hdr, k == 0);
      for (j = 0; j < 8; j++) send_byte(8'($urandom), 1'b0);
    end
    if (tail) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Receiver: pops at random with stall bursts, plus one long hold-off on
  // request so the decoder backs up and raises full.
  initial begin
    bit next_pop;
    bit cur_pop;
    int hold_left;
    int stall_left;
    cur_pop    = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (cur_pop && !empty) sb.check_word(sample, last, sound_end, loop_flag, block_index);
      if (hold_go) begin
        hold_go   = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_pop = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_pop = 1'b0;
      end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        next_pop   = 1'b0;
      end else begin
        next_pop = 1'b1;
      end
      cur_pop = next_pop;
      pop    <= next_pop;
    end
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int r;
    int k;
    // Opening stream, no new_sound at first so decoding starts from reset:
    // big shift with the strongest filter to hit both clamp limits, extreme
    // nibbles; then a shift above 12 with the end and loop bits set; two
    // bytes after the stop that must be dropped; a new sound that is cut
    // off mid-block by another new_sound.
    opening = '{9'h0CC, 9'h077, 9'h077, 9'h088, 9'h088, 9'h008, 9'h0F0, 9'h000, 9'h07F,
                9'h0FF, 9'h07F, 9'h088, 9'h080, 9'h008, 9'h0FF, 9'h000, 9'h077, 9'h011,
                9'h05A, 9'h0A5,
                9'h1D6, 9'h08F, 9'h0F8, 9'h070,
                9'h128, 9'h09C};

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 26; k++) send_byte(opening[k][7:0], opening[k][8]);
    wait_drained();

    // Back-pressure: the receiver holds off while bytes keep coming, then
    // the sender waits for the backlog to clear.
    tx_calm = 1'b1;
    hold_go = 1'b1;
    play_sound(3, 1'b1, 1'b0);
    wait_drained();
    tx_calm = 1'b0;

    // Random part: mostly well-formed sounds, some noise bytes with random
    // new_sound, and sounds left unfinished. Idling stops near the end.
    random_start = live_items;
    while (live_items - random_start < 740) begin
      if (live_items - random_start >= 630) begin
        tx_calm = 1'b1;
        rx_calm = 1'b1;
      end
      r = $urandom_range(0, 9);
      if (r == 0) begin
        repeat ($urandom_range(1, 12))
          send_byte(8'($urandom), $urandom_range(0, 3) == 0);
      end else begin
        play_sound($urandom_range(1, 4), $urandom_range(0, 3) != 0,
                   $urandom_range(0, 2) == 0);
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected words never came", sb.expected_q.size()));

    $display("Run covered %0d decoded bytes, %0d dropped, %0d words checked,",
             live_items, sb.bytes_dropped, sb.words_checked);
    $display("  %0d sounds stopped (%0d at the block cap), %0d mismatches.",
             sb.sounds_closed, sb.cap_stops, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
